### rtl/matrix_keypad_change_detector_assert.svh
// assertion macros for the keypad change detector
`ifndef MATRIX_KEYPAD_CHANGE_DETECTOR_ASSERT_SVH
`define MATRIX_KEYPAD_CHANGE_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MKCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad change detector check failed");

// next-cycle implication, disabled during reset
`define MKCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad change detector check failed");

`endif

### rtl/mkcd_pkg.sv
// shared constants and types for the keypad change detector
`timescale 1ns / 1ps

package mkcd_pkg;

    localparam int PIN_W            = 8;
    localparam int ROW_IDX_W        = $clog2(PIN_W);
    localparam int PEND_W           = 2 * PIN_W;
    localparam int PEND_IDX_W       = $clog2(PEND_W);
    localparam int TABLE_DEPTH      = 64;
    localparam int KEY_W            = $clog2(TABLE_DEPTH);
    localparam int CODE_W           = 10;
    localparam int DEF_ROW_COUNT    = 8;
    localparam int DEF_COLUMN_COUNT = 8;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic              last;
        logic [PEND_W-1:0] rest;
    } pick_t;

endpackage

### rtl/mkcd_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mkcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mkcd_pick.sv
// event picker: lowest pending change bit to key index
`timescale 1ns / 1ps

module mkcd_pick
    import mkcd_pkg::*;
(
    input  logic [PEND_W-1:0] pending,
    input  logic [KEY_W-1:0]  base,
    output pick_t             pick
);

    logic [PEND_IDX_W-1:0] sel;
    logic [PEND_W-1:0]     rest;

    always_comb
    begin
        sel = '0;
        for (int i = PEND_W - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                sel = PEND_IDX_W'(i);
            end
        end
        rest = pending & (pending - PEND_W'(1));
        pick.key     = base + KEY_W'(sel[ROW_IDX_W-1:0]);
        pick.pressed = !sel[ROW_IDX_W];
        pick.rest    = rest;
        pick.last    = (rest == '0);
    end

endmodule

### rtl/matrix_keypad_change_detector.sv
// empty results go from ST_LOAD to the output register; events are first picked in ST_FIND
// events leave one per cycle while out_stall is low, from the priority picker
// and the registered keycode ram read
// a new item is taken only once the last result of the previous one is in the output register
// reset clears column masks, keycode valid bits and all control state; event_enable resets to 1
`timescale 1ns / 1ps

module matrix_keypad_change_detector
    import mkcd_pkg::*;
#(
    parameter int ROW_COUNT    = DEF_ROW_COUNT,
    parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [2:0]        column,
    input  logic [PIN_W-1:0]  row_pins,
    input  logic [KEY_W-1:0]  entry_index,
    input  logic [CODE_W-1:0] entry_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              event_valid,
    output logic [KEY_W-1:0]  key_index,
    output logic [CODE_W-1:0] key_code,
    output logic              pressed,
    output logic              any_held,
    output logic              last
);

`include "matrix_keypad_change_detector_assert.svh"

    localparam int CIDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam logic [PIN_W-1:0] ROW_MASK =
        (ROW_COUNT >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << ROW_COUNT) - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic                    event_enable_reg;
    logic [PIN_W-1:0]        mask_reg [COLUMN_COUNT];
    logic [COLUMN_COUNT-1:0] held_reg;
    logic [COLUMN_COUNT-1:0] held_upd;
    logic [TABLE_DEPTH-1:0]  known_reg;

    logic [PEND_W-1:0]       pending_reg;
    logic [KEY_W-1:0]        base_reg;
    logic                    any_held_reg;

    logic [KEY_W-1:0]        cur_key_reg;
    logic                    cur_pressed_reg;
    logic                    cur_last_reg;
    logic                    cur_event_reg;
    logic                    cur_known_reg;

    logic                    out_valid_reg;
    logic                    event_valid_reg;
    logic [KEY_W-1:0]        key_index_reg;
    logic [CODE_W-1:0]       key_code_reg;
    logic                    pressed_reg;
    logic                    any_held_out_reg;
    logic                    last_reg;

    logic                    in_take;
    logic                    out_free;
    logic                    do_find;
    logic                    load_out;
    logic                    col_ok;
    logic [CIDX_W-1:0]       col_idx;
    logic [PIN_W-1:0]        now_mask;
    logic [PIN_W-1:0]        prev_mask;
    logic [PIN_W-1:0]        down_mask;
    logic [PIN_W-1:0]        up_mask;
    logic [PEND_W-1:0]       change_vec;
    logic                    has_events;
    logic [CODE_W-1:0]       rd_data;
    pick_t                   pick;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_LOAD) && out_free;
    assign do_find  = (state_reg == ST_FIND) || (load_out && !cur_last_reg);

    assign col_ok       = (int'(column) < COLUMN_COUNT);
    assign col_idx      = col_ok ? CIDX_W'(column) : '0;
    assign now_mask     = ~row_pins & ROW_MASK;
    assign prev_mask    = mask_reg[col_idx];
    assign down_mask    = (now_mask ^ prev_mask) & now_mask;
    assign up_mask      = (now_mask ^ prev_mask) & prev_mask;
    assign change_vec   = {up_mask, down_mask};
    assign has_events   = event_enable_reg && (change_vec != '0);

    always_comb
    begin
        held_upd          = held_reg;
        held_upd[col_idx] = |now_mask;
    end

    mkcd_pick u_pick (
        .pending (pending_reg),
        .base    (base_reg),
        .pick    (pick)
    );

    mkcd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_code_ram (
        .clk   (clk),
        .we    (in_take && (op == OP_WRITE)),
        .waddr (entry_index),
        .wdata (entry_code),
        .re    (do_find),
        .raddr (pick.key),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if ((op == OP_SCAN) && col_ok && has_events)
                    begin
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FIND:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free && cur_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            event_enable_reg <= 1'b1;
            held_reg         <= '0;
            known_reg        <= '0;
            out_valid_reg    <= 1'b0;
            for (int c = 0; c < COLUMN_COUNT; c++)
            begin
                mask_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                event_enable_reg <= cfg_wr_data;
            end
            if (in_take && (op == OP_WRITE))
            begin
                known_reg[entry_index] <= 1'b1;
            end
            if (in_take && (op == OP_SCAN) && col_ok)
            begin
                mask_reg[col_idx] <= now_mask;
                held_reg          <= held_upd;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working payload and output register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pending_reg     <= has_events ? change_vec : '0;
            base_reg        <= KEY_W'(int'(column) * ROW_COUNT);
            any_held_reg    <= ((op == OP_SCAN) && col_ok) ? (|held_upd) : (|held_reg);
            cur_key_reg     <= '0;
            cur_pressed_reg <= 1'b0;
            cur_last_reg    <= 1'b1;
            cur_event_reg   <= 1'b0;
            cur_known_reg   <= 1'b0;
        end
        else if (do_find)
        begin
            pending_reg     <= pick.rest;
            cur_key_reg     <= pick.key;
            cur_pressed_reg <= pick.pressed;
            cur_last_reg    <= pick.last;
            cur_event_reg   <= 1'b1;
            cur_known_reg   <= known_reg[pick.key];
        end
        if (load_out)
        begin
            event_valid_reg  <= cur_event_reg;
            key_index_reg    <= cur_key_reg;
            key_code_reg     <= (cur_event_reg && cur_known_reg) ? rd_data : '0;
            pressed_reg      <= cur_pressed_reg;
            any_held_out_reg <= any_held_reg;
            last_reg         <= cur_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = event_valid_reg;
    assign key_index   = key_index_reg;
    assign key_code    = key_code_reg;
    assign pressed     = pressed_reg;
    assign any_held    = any_held_out_reg;
    assign last        = last_reg;

    `MKCD_ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, in_take, state_reg != ST_IDLE)
    `MKCD_ASSERT_NOW(a_find_has_work, clk, rst_n, state_reg == ST_FIND, pending_reg != '0)
    `MKCD_ASSERT_NEXT(a_find_then_load, clk, rst_n, state_reg == ST_FIND, state_reg == ST_LOAD)
    `MKCD_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_valid_reg && !event_valid_reg, last_reg)

endmodule
